>>> hw/rtl/ted_pkg.sv
// Shared types and constants for the text encoding detector.
// Has no dependencies; imported by the top level and its checker.
`default_nettype none

package ted_pkg;

    localparam int COUNT_BITS = 32;
    localparam int TEN_W      = COUNT_BITS + 4;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [TEN_W-1:0]      t_ten;

    localparam t_count CNT_MAX = {COUNT_BITS{1'b1}};
    // 10 * CNT_MAX: the top value of a zero counter kept in tenfold form
    localparam t_ten   TEN_MAX = ({4'b0, CNT_MAX} << 3) + ({4'b0, CNT_MAX} << 1);
    localparam t_ten   TEN_STEP = TEN_W'(10);

    typedef enum logic [2:0] {
        ENC_UTF8_BOM = 3'd0,
        ENC_UTF8     = 3'd1,
        ENC_UTF16_LE = 3'd2,
        ENC_UTF16_BE = 3'd3,
        ENC_ANSI     = 3'd4
    } t_encoding;

    localparam int TDATA_W = 8;

endpackage

`default_nettype wire

>>> hw/rtl/text_encoding_detector_top.sv
// Text encoding detector: byte stream in, one encoding code per file out.
// Depends on ted_pkg for counter widths and encoding codes.
//
// Usage:
//   Slave channel: one file byte per transfer in s_axis_tdata[7:0], with
//   s_axis_tlast high on the final byte of the file.
//   Master channel: one transfer per file, the encoding code in
//   m_axis_tdata[2:0] (0 utf8 bom, 1 utf8, 2 utf16 le, 3 utf16 be, 4 ansi).
//   Throughput: one byte per cycle, sustained across file boundaries while
//   the output register is free. Each byte passes the input register, then
//   the update logic that writes the counters and, for the last byte of a
//   file, the result register, from which the code goes to the master side.
//   The zero-byte test against length/10 is done as 10*zeros > length, with
//   the zero counters kept in tenfold form so it is one add and one compare.
//   Stall: while a result waits in the output register, further bytes that
//   do not end a file keep flowing; a last byte waits in the input register
//   until the output register is free, and s_axis_tready drops behind it.
//   Reset (synchronous, active low) empties both registers and clears all
//   counters; the block is ready as soon as reset is released.
`default_nettype none

module text_encoding_detector_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire  [7:0]                   i_s_axis_tdata,   // [7:0] data_byte
    input  wire                          i_s_axis_tlast,   // last
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    output logic [ted_pkg::TDATA_W-1:0]  o_m_axis_tdata    // [2:0] encoding, rest zero
);
    import ted_pkg::*;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // file state
    t_count      r_count, n_count;
    logic [23:0] r_lead, n_lead;
    logic [1:0]  r_pend, n_pend;
    logic        r_broken, n_broken;
    t_ten        r_ten_odd, n_ten_odd;
    t_ten        r_ten_even, n_ten_even;

    // output register
    logic      r_out_valid, n_out_valid;
    t_encoding r_out_enc, n_out_enc;

    logic s_xfer, out_free, adv, is_zero, odd_pos;
    logic broken_fin;
    logic [7:0] b0, b1, b2;

    assign s_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign adv      = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || adv;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(TDATA_W-3){1'b0}}, r_out_enc};

    always_comb begin
        n_in_valid = s_xfer || (r_in_valid && !adv);

        is_zero = (r_in_byte == 8'h00);
        odd_pos = r_count[0];

        n_count = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;

        n_lead = r_lead;
        if (r_count < COUNT_BITS'(3)) begin
            unique case (r_count[1:0])
                2'd0:    n_lead[7:0]   = r_in_byte;
                2'd1:    n_lead[15:8]  = r_in_byte;
                default: n_lead[23:16] = r_in_byte;
            endcase
        end

        // UTF-8 structure check, sticky once broken
        n_pend   = r_pend;
        n_broken = r_broken;
        if (!r_broken) begin
            if (r_pend != 2'd0) begin
                if (r_in_byte[7:6] != 2'b10) n_broken = 1'b1;
                else                         n_pend   = r_pend - 2'd1;
            end else if (r_in_byte[7]) begin
                priority if (r_in_byte[7:5] == 3'b110)   n_pend   = 2'd1;
                else if (r_in_byte[7:4] == 4'b1110)      n_pend   = 2'd2;
                else if (r_in_byte[7:3] == 5'b11110)     n_pend   = 2'd3;
                else                                     n_broken = 1'b1;
            end
        end

        n_ten_odd  = r_ten_odd;
        n_ten_even = r_ten_even;
        if (is_zero && odd_pos && r_ten_odd != TEN_MAX)
            n_ten_odd = r_ten_odd + TEN_STEP;
        if (is_zero && !odd_pos && r_ten_even != TEN_MAX)
            n_ten_even = r_ten_even + TEN_STEP;

        broken_fin = n_broken || (n_pend != 2'd0);
        b0 = n_lead[7:0];
        b1 = n_lead[15:8];
        b2 = n_lead[23:16];

        priority if (n_count >= COUNT_BITS'(3) && b0 == 8'hEF && b1 == 8'hBB
                     && b2 == 8'hBF)
            n_out_enc = ENC_UTF8_BOM;
        else if (n_count >= COUNT_BITS'(2) && b0 == 8'hFF && b1 == 8'hFE)
            n_out_enc = ENC_UTF16_LE;
        else if (n_count >= COUNT_BITS'(2) && b0 == 8'hFE && b1 == 8'hFF)
            n_out_enc = ENC_UTF16_BE;
        else if (!broken_fin)
            n_out_enc = ENC_UTF8;
        else if (n_count >= COUNT_BITS'(4) && n_ten_odd > {4'b0, n_count})
            n_out_enc = ENC_UTF16_LE;
        else if (n_count >= COUNT_BITS'(4) && n_ten_even > {4'b0, n_count})
            n_out_enc = ENC_UTF16_BE;
        else
            n_out_enc = ENC_ANSI;

        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (adv && r_in_last) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_lead      <= '0;
            r_pend      <= '0;
            r_broken    <= 1'b0;
            r_ten_odd   <= '0;
            r_ten_even  <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (adv) begin
                if (r_in_last) begin
                    // file closed: back to the empty-file state
                    r_count    <= '0;
                    r_lead     <= '0;
                    r_pend     <= '0;
                    r_broken   <= 1'b0;
                    r_ten_odd  <= '0;
                    r_ten_even <= '0;
                end else begin
                    r_count    <= n_count;
                    r_lead     <= n_lead;
                    r_pend     <= n_pend;
                    r_broken   <= n_broken;
                    r_ten_odd  <= n_ten_odd;
                    r_ten_even <= n_ten_even;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (adv && r_in_last) r_out_enc <= n_out_enc;
    end

endmodule

`default_nettype wire

>>> hw/rtl/ted_checker.sv
// Port-level checker for the text encoding detector, bound to the top level.
// Depends on ted_pkg for the encoding codes and tdata width.
`default_nettype none

module ted_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_s_axis_tvalid,
    input wire                         o_s_axis_tready,
    input wire [7:0]                   i_s_axis_tdata,
    input wire                         i_s_axis_tlast,
    input wire                         o_m_axis_tvalid,
    input wire                         i_m_axis_tready,
    input wire [ted_pkg::TDATA_W-1:0]  o_m_axis_tdata
);
    import ted_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // result code is a defined encoding, padding zero
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata <= TDATA_W'(ENC_ANSI)))
        else $error("encoding code out of range");

    // reset empties the result register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // reset empties the input register, so the block is ready
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("not ready after reset");

    // while the result side is free, bytes are never refused
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with free output");

endmodule

bind text_encoding_detector_top ted_checker u_ted_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

>>> dv/encoding_checker.sv
// Scoreboard for the text encoding detector: watches both stream channels,
// predicts the encoding code of each file and compares it with the block's output.
// Depends on ted_pkg for the counter type and the encoding codes.

module encoding_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_in_ready,
    input  wire  [7:0]                  i_in_byte,
    input  wire                         i_in_last,
    input  wire                         i_out_valid,
    input  wire                         i_out_ready,
    input  wire  [ted_pkg::TDATA_W-1:0] i_out_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_bytes,
    output int                          o_files,
    output logic [4:0]                  o_codes_seen
);

    localparam logic [7:0] MARK_EF = 8'hEF;
    localparam logic [7:0] MARK_BB = 8'hBB;
    localparam logic [7:0] MARK_BF = 8'hBF;
    localparam logic [7:0] MARK_FF = 8'hFF;
    localparam logic [7:0] MARK_FE = 8'hFE;

    // shadow copy of the per-file detection state
    ted_pkg::t_count    file_len;
    ted_pkg::t_count    zeros_odd;
    ted_pkg::t_count    zeros_even;
    logic [23:0]        head;
    logic [1:0]         owed;
    logic               utf8_bad;

    ted_pkg::t_encoding expected_codes[$];

    function automatic ted_pkg::t_count sat_bump(input ted_pkg::t_count v);
        return (v == ted_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic clear_file_state();
        file_len   = '0;
        zeros_odd  = '0;
        zeros_even = '0;
        head       = '0;
        owed       = '0;
        utf8_bad   = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic closes,
                             output logic done, output ted_pkg::t_encoding code);
        ted_pkg::t_count pos;
        ted_pkg::t_count tenth;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        pos  = file_len;
        done = 1'b0;
        code = ted_pkg::ENC_ANSI;
        if (pos < 3)
            head[pos*8 +: 8] = b;
        if (!utf8_bad) begin
            if (owed != 2'd0) begin
                if (b[7:6] != 2'b10)
                    utf8_bad = 1'b1;
                else
                    owed = owed - 2'd1;
            end else if (b[7]) begin
                if (b[7:5] == 3'b110)
                    owed = 2'd1;
                else if (b[7:4] == 4'b1110)
                    owed = 2'd2;
                else if (b[7:3] == 5'b11110)
                    owed = 2'd3;
                else
                    utf8_bad = 1'b1;
            end
        end
        if (b == 8'd0) begin
            if (pos[0])
                zeros_odd = sat_bump(zeros_odd);
            else
                zeros_even = sat_bump(zeros_even);
        end
        file_len = sat_bump(file_len);
        if (closes) begin
            // a sequence still open at end of file is truncated
            if (owed != 2'd0)
                utf8_bad = 1'b1;
            tenth = file_len / 10;
            b0 = head[7:0];
            b1 = head[15:8];
            b2 = head[23:16];
            if (file_len >= 3 && b0 == MARK_EF && b1 == MARK_BB && b2 == MARK_BF)
                code = ted_pkg::ENC_UTF8_BOM;
            else if (file_len >= 2 && b0 == MARK_FF && b1 == MARK_FE)
                code = ted_pkg::ENC_UTF16_LE;
            else if (file_len >= 2 && b0 == MARK_FE && b1 == MARK_FF)
                code = ted_pkg::ENC_UTF16_BE;
            else if (!utf8_bad)
                code = ted_pkg::ENC_UTF8;
            else if (file_len >= 4 && zeros_odd > tenth)
                code = ted_pkg::ENC_UTF16_LE;
            else if (file_len >= 4 && zeros_even > tenth)
                code = ted_pkg::ENC_UTF16_BE;
            else
                code = ted_pkg::ENC_ANSI;
            done = 1'b1;
            clear_file_state();
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_bytes      = 0;
        o_files      = 0;
        o_codes_seen = '0;
    end

    always @(posedge i_clk) begin : monitor
        logic               done;
        ted_pkg::t_encoding code;
        ted_pkg::t_encoding want;
        if (!i_rst_n) begin
            clear_file_state();
            expected_codes.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                take_byte(i_in_byte, i_in_last, done, code);
                o_bytes = o_bytes + 1;
                if (done)
                    expected_codes.push_back(code);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: result 0x%0h with no file outstanding", $time, i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_codes.pop_front();
                    o_files = o_files + 1;
                    o_codes_seen[want] = 1'b1;
                    // padding above the code must be zero too
                    if (i_out_data != ted_pkg::TDATA_W'(want)) begin
                        $display("%0t: encoding mismatch, expected %0d got %0d (tdata 0x%0h)",
                                 $time, want, i_out_data[2:0], i_out_data);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = expected_codes.size();
        end
    end

endmodule

>>> dv/text_encoding_detector_top_tb.sv
// Top of the text encoding detector testbench: clock, reset, byte-stream stimulus
// and result-side back-pressure; checking lives in encoding_checker.
// Depends on ted_pkg, encoding_checker and text_encoding_detector_top.

module text_encoding_detector_top_tb;

    typedef enum int {
        FILE_NOISE,
        FILE_TEXT,
        FILE_TEXT_BOM,
        FILE_WIDE_LE,
        FILE_WIDE_BE,
        FILE_MARK_LE,
        FILE_MARK_BE,
        FILE_DAMAGED,
        FILE_STUB
    } t_file_kind;

    localparam int RANDOM_BYTES  = 1900;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [7:0] MARK_EF = 8'hEF;
    localparam logic [7:0] MARK_BB = 8'hBB;
    localparam logic [7:0] MARK_BF = 8'hBF;
    localparam logic [7:0] MARK_FF = 8'hFF;
    localparam logic [7:0] MARK_FE = 8'hFE;

    logic                        i_clk;
    logic                        rst_n   = 1'b0;
    logic                        s_valid = 1'b0;
    logic [7:0]                  s_data  = 8'd0;
    logic                        s_last  = 1'b0;
    logic                        m_ready = 1'b0;
    wire                         s_ready;
    wire                         m_valid;
    wire [ted_pkg::TDATA_W-1:0]  m_data;

    int          fail_count;
    int          pending;
    int          bytes_seen;
    int          files_seen;
    logic [4:0]  codes_seen;

    logic        calm = 1'b0;
    logic [7:0]  file_q[$];
    int          bytes_sent = 0;
    int          files_sent = 0;

    text_encoding_detector_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    encoding_checker u_encoding_chk (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_byte    (s_data),
        .i_in_last    (s_last),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bytes      (bytes_seen),
        .o_files      (files_seen),
        .o_codes_seen (codes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // mostly no gap, some short ones, a few long ones; none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 12);
        if (r < 95)
            return $urandom_range(13, 48);
        return $urandom_range(49, 160);
    endfunction

    function automatic t_file_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return FILE_NOISE;
        if (r < 30) return FILE_TEXT;
        if (r < 40) return FILE_TEXT_BOM;
        if (r < 52) return FILE_WIDE_LE;
        if (r < 64) return FILE_WIDE_BE;
        if (r < 70) return FILE_MARK_LE;
        if (r < 76) return FILE_MARK_BE;
        if (r < 90) return FILE_DAMAGED;
        return FILE_STUB;
    endfunction

    // bytes that sit on the decision boundaries: marks, zero, bad leads
    function automatic logic [7:0] pick_stub_byte();
        case ($urandom_range(0, 8))
            0:       return 8'h00;
            1:       return MARK_EF;
            2:       return MARK_BB;
            3:       return MARK_BF;
            4:       return MARK_FF;
            5:       return MARK_FE;
            6:       return 8'h80;
            7:       return 8'hC3;
            default: return 8'h41;
        endcase
    endfunction

    task automatic add_cont(input int n);
        logic [7:0] v;
        repeat (n) begin
            v = 8'($urandom);
            file_q.push_back({2'b10, v[5:0]});
        end
    endtask

    // one well-formed UTF-8 character, ASCII most often
    task automatic add_text_char();
        logic [7:0] v;
        int         r;
        v = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r < 5) begin
            file_q.push_back({1'b0, v[6:0]});
        end else if (r < 7) begin
            file_q.push_back({3'b110, v[4:0]});
            add_cont(1);
        end else if (r < 9) begin
            file_q.push_back({4'b1110, v[3:0]});
            add_cont(2);
        end else begin
            file_q.push_back({5'b11110, v[2:0]});
            add_cont(3);
        end
    endtask

    // a 16-bit unit; zero_pct sets how often the high byte is zero
    task automatic add_wide_pair(input int zero_pct, input logic little);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'($urandom);
        hi = 8'($urandom);
        if ($urandom_range(0, 99) < zero_pct)
            hi = 8'd0;
        if (little) begin
            file_q.push_back(lo);
            file_q.push_back(hi);
        end else begin
            file_q.push_back(hi);
            file_q.push_back(lo);
        end
    endtask

    task automatic build_file(input t_file_kind kind, input int len);
        logic [7:0] v;
        int         pct;
        int         at;
        file_q.delete();
        pct = $urandom_range(0, 100);
        case (kind)
            FILE_NOISE: begin
                repeat (len) begin
                    v = 8'($urandom);
                    file_q.push_back(v);
                end
            end
            FILE_TEXT: begin
                while (file_q.size() < len)
                    add_text_char();
            end
            FILE_TEXT_BOM: begin
                file_q.push_back(MARK_EF);
                file_q.push_back(MARK_BB);
                file_q.push_back(MARK_BF);
                while (file_q.size() < len + 3)
                    add_text_char();
            end
            FILE_WIDE_LE, FILE_WIDE_BE: begin
                while (file_q.size() < len)
                    add_wide_pair(pct, kind == FILE_WIDE_LE);
                // odd length now and then
                if ($urandom_range(0, 3) == 0)
                    void'(file_q.pop_back());
            end
            FILE_MARK_LE, FILE_MARK_BE: begin
                file_q.push_back(kind == FILE_MARK_LE ? MARK_FF : MARK_FE);
                file_q.push_back(kind == FILE_MARK_LE ? MARK_FE : MARK_FF);
                while (file_q.size() < len + 2)
                    add_wide_pair(pct, kind == FILE_MARK_LE);
            end
            FILE_DAMAGED: begin
                while (file_q.size() < len)
                    add_text_char();
                v = 8'($urandom);
                case ($urandom_range(0, 3))
                    0: begin
                        at = $urandom_range(0, file_q.size() - 1);
                        file_q[at] = v;
                    end
                    1: file_q.push_back({3'b110, v[4:0]});
                    2: begin
                        file_q.push_back({4'b1110, v[3:0]});
                        if (v[7]) add_cont(1);
                    end
                    default: begin
                        at = $urandom_range(0, file_q.size() - 1);
                        file_q[at] = {5'b11111, v[2:0]};
                    end
                endcase
            end
            default: begin
                repeat ($urandom_range(1, 5))
                    file_q.push_back(pick_stub_byte());
            end
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic drive_byte(input logic [7:0] b, input logic closes, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= closes;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_q.size(); i++)
            drive_byte(file_q[i], i == file_q.size() - 1, pick_gap());
        files_sent = files_sent + 1;
    endtask

    // result-side back-pressure
    initial begin : sink_pacing
        int i;
        int n;
        wait (rst_n === 1'b1);
        forever begin
            n = pick_gap();
            for (i = 0; i < n; i++) begin
                @(negedge i_clk);
                m_ready <= 1'b0;
            end
            n = $urandom_range(1, 16);
            for (i = 0; i < n; i++) begin
                @(negedge i_clk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_file_kind kind;
        int         len;
        repeat (5) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // utf8 mark
        file_q = '{8'hEF, 8'hBB, 8'hBF};
        send_file();
        // utf16 le and be marks alone
        file_q = '{8'hFF, 8'hFE};
        send_file();
        file_q = '{8'hFE, 8'hFF};
        send_file();
        // single zero byte, single bad lead
        file_q = '{8'h00};
        send_file();
        file_q = '{8'hFF};
        send_file();
        // truncated two-byte sequence
        file_q = '{8'hC3};
        send_file();
        // continuation byte where a lead belongs
        file_q = '{8'h80, 8'h41};
        send_file();
        // missing continuation
        file_q = '{8'hE2, 8'h41, 8'h82};
        send_file();
        // four-byte lead, two continuations, then top ASCII byte 7F where the third belongs
        file_q = '{8'hF0, 8'h9F, 8'h98, 8'h7F};
        send_file();
        // lead at F8 breaks the check; zeros at odd positions decide
        file_q = '{8'hF8, 8'h00, 8'h41, 8'h00};
        send_file();

        while (bytes_sent < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 4) == 0);
            kind = pick_kind();
            len  = pick_len();
            build_file(kind, len);
            bytes_sent = bytes_sent + file_q.size();
            send_file();
            // drain everything before going on
            if (files_sent == 40 || $urandom_range(0, 19) == 0) begin
                s_valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
        end
        s_valid <= 1'b0;
        calm = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d bytes in %0d files (%0d results checked), codes seen %b",
                 bytes_seen, files_sent, files_seen, codes_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ted_pkg.sv
hw/rtl/text_encoding_detector_top.sv
hw/rtl/ted_checker.sv
dv/encoding_checker.sv
dv/text_encoding_detector_top_tb.sv
